@@ rtl/oash_pkg.sv @@
// Shared types, constants and helpers of the open-addressing string hash table.
// Depends on nothing; every other rtl file but oash_ram imports it.
package oash_pkg;

    localparam int TABLE_SLOTS = 101;
    localparam int PROBE_LIMIT = 20;
    localparam int KEY_BYTES   = 15;

    localparam int KEY_LANES = 15;
    localparam int HASH_MULT = 19;
    localparam int PROBE_LIN = 23;

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
    localparam int J_W     = $clog2(PROBE_LIMIT + 1);
    localparam int KEY_W   = 8 * KEY_LANES;
    localparam int POS_W   = $clog2(KEY_LANES + 1);
    localparam int PROD_W  = 8 + POS_W;
    localparam int SUM_MAX = 255 * KEY_BYTES * (KEY_BYTES + 1) / 2;
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int X_W     = $clog2(SUM_MAX * HASH_MULT + 1);
    localparam int RECIP_M = (2 ** X_W) / TABLE_SLOTS;
    localparam int STEP0   = (PROBE_LIN + 1) % TABLE_SLOTS;
    localparam int STEP_INC = 2 % TABLE_SLOTS;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [1:0] {
        REQ_ADD, REQ_DEL, REQ_READ, REQ_CLEAR
    } t_req;

    typedef enum logic [2:0] {
        STS_INSERTED, STS_PRESENT, STS_NO_SLOT, STS_REMOVED,
        STS_NOT_FOUND, STS_EMPTY, STS_READ, STS_CLEARED
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_HASH, S_PROBE, S_RDADDR, S_FIN
    } t_state;

    typedef struct packed {
        logic  done;
        logic  empty;
        t_slot home;
    } t_hash_res;

    function automatic t_slot slot_add(input t_slot a, input t_slot b);
        logic [SLOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (SLOT_W+1)'(TABLE_SLOTS)) begin
            s = s - (SLOT_W+1)'(TABLE_SLOTS);
        end
        return s[SLOT_W-1:0];
    endfunction

endpackage

@@ rtl/oash_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oash_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/oash_lane.sv @@
// One key-byte lane: masks the byte at the key end and weights it by its position.
// Depends on oash_pkg.
module oash_lane (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [7:0]                 i_byte,
    input  logic                       i_alive,
    input  logic [oash_pkg::POS_W-1:0] i_pos,
    output logic [7:0]                 o_byte,
    output logic [oash_pkg::PROD_W-1:0] o_prod
);
    import oash_pkg::*;

    logic [7:0]        r_byte;
    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_byte <= i_alive ? i_byte : 8'd0;
            r_prod <= i_alive ? PROD_W'(i_byte) * PROD_W'(i_pos) : '0;
        end
    end

    assign o_byte = r_byte;
    assign o_prod = r_prod;
endmodule

@@ rtl/oash_hash.sv @@
// Home-slot hash: byte lanes in parallel, then sum, scale and modulo by reciprocal.
// Depends on oash_pkg and oash_lane.
module oash_hash (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [63:0]                i_key_low,
    input  logic [55:0]                i_key_high,
    output logic [oash_pkg::KEY_W-1:0] o_key,
    output oash_pkg::t_hash_res        o_res
);
    import oash_pkg::*;

    logic [KEY_W-1:0]  raw;
    logic [KEY_LANES-1:0] alive;
    logic [7:0]        nbyte [KEY_LANES];
    logic [PROD_W-1:0] prod [KEY_LANES];
    logic [SUM_W-1:0]  sum;

    logic              r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [SUM_W-1:0]  r_sum;
    logic [X_W-1:0]    r_x, r_x3;
    logic [2*X_W-1:0]  r_qp;
    logic [SLOT_W:0]   r_rem;
    t_slot             r_home;
    logic [X_W-1:0]    quo;
    logic [X_W+SLOT_W-1:0] qn;

    assign raw = {i_key_high, i_key_low};

    always_comb begin
        for (int i = 0; i < KEY_LANES; i++) begin
            alive[i] = (i < KEY_BYTES) && (raw[8*i +: 8] != 8'd0)
                       && ((i == 0) ? 1'b1 : alive[(i == 0) ? 0 : i-1]);
        end
    end

    for (genvar g = 0; g < KEY_LANES; g++) begin : g_lane
        oash_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (i_start),
            .i_byte  (raw[8*g +: 8]),
            .i_alive (alive[g]),
            .i_pos   (POS_W'(g + 1)),
            .o_byte  (nbyte[g]),
            .o_prod  (prod[g])
        );
        assign o_key[8*g +: 8] = nbyte[g];
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < KEY_LANES; i++) begin
            sum = sum + SUM_W'(prod[i]);
        end
    end

    assign quo = r_qp[2*X_W-1:X_W];
    assign qn  = (X_W+SLOT_W)'(quo) * (X_W+SLOT_W)'(TABLE_SLOTS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v0 <= i_start;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
        r_sum  <= sum;
        r_x    <= X_W'(r_sum) * X_W'(HASH_MULT);
        r_qp   <= (2*X_W)'(r_x) * (2*X_W)'(RECIP_M);
        r_x3   <= r_x;
        r_rem  <= (SLOT_W+1)'((X_W+SLOT_W)'(r_x3) - qn);
        r_home <= (r_rem >= (SLOT_W+1)'(TABLE_SLOTS))
                  ? SLOT_W'(r_rem - (SLOT_W+1)'(TABLE_SLOTS)) : SLOT_W'(r_rem);
    end

    assign o_res.done  = r_v5;
    assign o_res.empty = (nbyte[0] == 8'd0);
    assign o_res.home  = r_home;
endmodule

@@ rtl/open_addressing_string_hash_table_core.sv @@
// Top level of the open-addressing string hash table with quadratic probing.
// Depends on oash_pkg, oash_hash and oash_ram.
//
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with o_valid, and cannot be held off. Add and
// delete first hash the key, then visit up to 20 probe slots (the key memory
// returns one slot per cycle, plus the first key read) and end in a finish
// state; an empty key skips the probes. A read passes through the read-address
// and finish states, a clear only through finish; no new request is taken until
// the state machine is back in idle. Slot marks live in flip-flops, so clear is
// immediate and no clearing pass follows reset.
module open_addressing_string_hash_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_key_low,
    input  logic [55:0] i_key_high,
    input  logic [6:0]  i_read_index,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [6:0]  o_slot_index,
    output logic [6:0]  o_occupied_count,
    output logic        o_slot_occupied,
    output logic [63:0] o_slot_key_low,
    output logic [55:0] o_slot_key_high
);
    import oash_pkg::*;

    t_state r_state, n_state;
    t_req   r_req;
    logic [6:0] r_ridx;
    logic [TABLE_SLOTS-1:0] r_occ, r_del;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [KEY_W-1:0] key, rdata;
    t_hash_res hres;

    t_slot r_s, r_d, r_cs, r_free_s, r_hit_s;
    logic [J_W-1:0] r_ji;
    logic r_cv, r_clast, r_have, r_found;

    logic cmp_occ, cmp_del, cmp_match, stop, probe_done;
    logic accept, hash_go, ram_we;
    t_slot raddr, ridx_s;
    logic in_range;

    logic n_valid, n_socc, set_occ, set_del, clr_all;
    t_status n_status;
    t_slot n_sidx, wslot;
    logic [KEY_W-1:0] n_skey;

    logic r_valid;
    logic [2:0] r_status;
    logic [6:0] r_sidx;
    logic r_socc;
    logic [KEY_W-1:0] r_skey;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign hash_go = accept && (t_req'(i_req_type) inside {REQ_ADD, REQ_DEL});

    oash_hash u_hash (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (hash_go),
        .i_key_low  (i_key_low),
        .i_key_high (i_key_high),
        .o_key      (key),
        .o_res      (hres)
    );

    assign ridx_s   = SLOT_W'(r_ridx);
    assign in_range = 32'(r_ridx) < TABLE_SLOTS;
    assign raddr    = (r_state == S_PROBE) ? r_s : ridx_s;

    oash_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SLOTS)) u_keys (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wslot),
        .i_wdata (key),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign cmp_occ   = r_occ[r_cs];
    assign cmp_del   = r_del[r_cs];
    assign cmp_match = cmp_occ && (rdata == key);
    assign stop      = (r_req == REQ_ADD) ? ((!cmp_occ && !cmp_del) || cmp_match)
                                          : cmp_match;
    assign probe_done = r_cv && (stop || r_clast);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_req'(i_req_type))
                        REQ_CLEAR: n_state = S_FIN;
                        REQ_READ:  n_state = S_RDADDR;
                        default:   n_state = S_HASH;
                    endcase
                end
            end
            S_HASH: begin
                if (hres.done) begin
                    n_state = hres.empty ? S_FIN : S_PROBE;
                end
            end
            S_PROBE: begin
                if (probe_done) begin
                    n_state = S_FIN;
                end
            end
            S_RDADDR: n_state = S_FIN;
            S_FIN:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_valid  = 1'b0;
        n_status = STS_CLEARED;
        n_sidx   = '0;
        n_socc   = 1'b0;
        n_skey   = '0;
        n_cnt    = r_cnt;
        set_occ  = 1'b0;
        set_del  = 1'b0;
        clr_all  = 1'b0;
        ram_we   = 1'b0;
        wslot    = r_free_s;
        if (r_state == S_FIN) begin
            n_valid = 1'b1;
            case (r_req)
                REQ_CLEAR: begin
                    clr_all = 1'b1;
                    n_cnt   = '0;
                end
                REQ_READ: begin
                    n_status = STS_READ;
                    n_socc   = in_range && r_occ[ridx_s];
                    n_skey   = n_socc ? rdata : '0;
                end
                REQ_ADD: begin
                    if (hres.empty) begin
                        n_status = STS_EMPTY;
                    end else if (r_found) begin
                        n_status = STS_PRESENT;
                    end else if (r_have) begin
                        n_status = STS_INSERTED;
                        n_sidx   = r_free_s;
                        set_occ  = 1'b1;
                        ram_we   = 1'b1;
                        n_cnt    = r_cnt + 1'b1;
                    end else begin
                        n_status = STS_NO_SLOT;
                    end
                end
                default: begin
                    wslot = r_hit_s;
                    if (hres.empty) begin
                        n_status = STS_EMPTY;
                    end else if (r_found) begin
                        n_status = STS_REMOVED;
                        n_sidx   = r_hit_s;
                        set_del  = 1'b1;
                        n_cnt    = r_cnt - 1'b1;
                    end else begin
                        n_status = STS_NOT_FOUND;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_del   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
            r_cv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
            if (clr_all) begin
                r_occ <= '0;
                r_del <= '0;
            end
            if (set_occ) begin
                r_occ[wslot] <= 1'b1;
                r_del[wslot] <= 1'b0;
            end
            if (set_del) begin
                r_occ[wslot] <= 1'b0;
                r_del[wslot] <= 1'b1;
            end
            r_cv <= (r_state == S_PROBE) && (r_ji < J_W'(PROBE_LIMIT));
        end

        if (accept) begin
            r_req  <= t_req'(i_req_type);
            r_ridx <= i_read_index;
        end

        if (r_state == S_HASH) begin
            r_s     <= hres.home;
            r_d     <= SLOT_W'(STEP0);
            r_ji    <= '0;
            r_have  <= 1'b0;
            r_found <= 1'b0;
        end else if (r_state == S_PROBE) begin
            if (r_ji < J_W'(PROBE_LIMIT)) begin
                r_cs    <= r_s;
                r_clast <= (r_ji == J_W'(PROBE_LIMIT - 1));
                r_s     <= slot_add(r_s, r_d);
                r_d     <= slot_add(r_d, SLOT_W'(STEP_INC));
                r_ji    <= r_ji + 1'b1;
            end
            if (r_cv) begin
                if (!cmp_occ && !r_have) begin
                    r_have   <= 1'b1;
                    r_free_s <= r_cs;
                end
                if (cmp_match && !r_found) begin
                    r_found <= 1'b1;
                    r_hit_s <= r_cs;
                end
            end
        end

        r_status <= n_status;
        r_sidx   <= (r_req == REQ_READ) ? r_ridx : 7'(n_sidx);
        r_socc   <= n_socc;
        r_skey   <= n_skey;
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_slot_index     = r_sidx;
    assign o_occupied_count = 7'(r_cnt);
    assign o_slot_occupied  = r_socc;
    assign o_slot_key_low   = r_skey[63:0];
    assign o_slot_key_high  = r_skey[KEY_W-1:64];

`ifndef SYNTHESIS
    a_valid_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_FIN)) else $error("result without finish");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy) else $error("accepted transaction not busy");
    a_marks_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ & r_del) == '0) else $error("slot both occupied and deleted");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= TABLE_SLOTS) else $error("occupied count overflow");
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STS_CLEARED) |-> o_occupied_count == 7'd0)
        else $error("clear left slots occupied");
`endif
endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for open_addressing_string_hash_table_core.
// Drives add/delete/read/clear requests, predicts each result with a model of
// the hash table, and checks every strobed result. Depends on oash_pkg and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import oash_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam logic [1:0] MARK_FREE = 2'd0;
    localparam logic [1:0] MARK_OCC  = 2'd1;
    localparam logic [1:0] MARK_DEL  = 2'd2;

    typedef struct packed {
        t_req        req;
        logic [63:0] klo;
        logic [55:0] khi;
        logic [6:0]  ridx;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [6:0]  sidx;
        logic [6:0]  count;
        logic        occ;
        logic [63:0] klo;
        logic [55:0] khi;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type = '0;
    logic [63:0] i_key_low = '0;
    logic [55:0] i_key_high = '0;
    logic [6:0]  i_read_index = '0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [6:0]  o_slot_index;
    logic [6:0]  o_occupied_count;
    logic        o_slot_occupied;
    logic [63:0] o_slot_key_low;
    logic [55:0] o_slot_key_high;

    open_addressing_string_hash_table_core uut (.*);

    always #4 i_clk = ~i_clk;

    logic [1:0]  tbl_mark [TABLE_SLOTS];
    logic [63:0] tbl_klo [TABLE_SLOTS];
    logic [55:0] tbl_khi [TABLE_SLOTS];
    int          tbl_used;

    t_request pending_reqs[$];
    t_answer  expected_answers[$];
    int       errors = 0;
    bit       stim_done = 1'b0;
    int       cycle_count = 0;
    logic [63:0] key_pool_lo [16];
    logic [55:0] key_pool_hi [16];

    function automatic t_answer table_apply(t_request r);
        t_answer a;
        logic [7:0] b [15];
        logic [63:0] nlo;
        logic [55:0] nhi;
        int len, sum, home, s, j;
        bit ended, found;
        a = '0;
        nlo = '0;
        nhi = '0;
        len = 0;
        ended = 1'b0;
        found = 1'b0;
        case (r.req)
            REQ_CLEAR: begin
                foreach (tbl_mark[i]) tbl_mark[i] = MARK_FREE;
                tbl_used = 0;
                a.status = STS_CLEARED;
            end
            REQ_READ: begin
                a.status = STS_READ;
                a.sidx = r.ridx;
                if (r.ridx < TABLE_SLOTS && tbl_mark[r.ridx] == MARK_OCC) begin
                    a.occ = 1'b1;
                    a.klo = tbl_klo[r.ridx];
                    a.khi = tbl_khi[r.ridx];
                end
            end
            default: begin
                for (int i = 0; i < 15; i++) begin
                    b[i] = (i < 8) ? r.klo[8*i +: 8] : r.khi[8*(i-8) +: 8];
                    if (b[i] == 8'd0) ended = 1'b1;
                    if (ended) b[i] = 8'd0;
                    else len++;
                    if (i < 8) nlo[8*i +: 8] = b[i];
                    else nhi[8*(i-8) +: 8] = b[i];
                end
                sum = 0;
                for (int i = 0; i < len; i++) sum += b[i] * (i + 1);
                home = (sum * 19) % TABLE_SLOTS;
                if (len == 0) begin
                    a.status = STS_EMPTY;
                end else if (r.req == REQ_ADD) begin
                    for (j = 0; j < PROBE_LIMIT; j++) begin
                        s = (home + j*j + 23*j) % TABLE_SLOTS;
                        if (tbl_mark[s] == MARK_FREE) break;
                        if (tbl_mark[s] == MARK_OCC && tbl_klo[s] == nlo && tbl_khi[s] == nhi) begin
                            found = 1'b1;
                            break;
                        end
                    end
                    if (found) begin
                        a.status = STS_PRESENT;
                    end else begin
                        a.status = STS_NO_SLOT;
                        for (j = 0; j < PROBE_LIMIT; j++) begin
                            s = (home + j*j + 23*j) % TABLE_SLOTS;
                            if (tbl_mark[s] != MARK_OCC) begin
                                tbl_mark[s] = MARK_OCC;
                                tbl_klo[s] = nlo;
                                tbl_khi[s] = nhi;
                                tbl_used++;
                                a.status = STS_INSERTED;
                                a.sidx = 7'(s);
                                break;
                            end
                        end
                    end
                end else begin
                    a.status = STS_NOT_FOUND;
                    for (j = 0; j < PROBE_LIMIT; j++) begin
                        s = (home + j*j + 23*j) % TABLE_SLOTS;
                        if (tbl_mark[s] == MARK_OCC && tbl_klo[s] == nlo && tbl_khi[s] == nhi) begin
                            tbl_mark[s] = MARK_DEL;
                            tbl_used--;
                            a.status = STS_REMOVED;
                            a.sidx = 7'(s);
                            break;
                        end
                    end
                end
            end
        endcase
        a.count = 7'(tbl_used);
        return a;
    endfunction

    function automatic t_request key_request(t_req rq, logic [63:0] lo, logic [55:0] hi);
        t_request r;
        r.req = rq;
        r.klo = lo;
        r.khi = hi;
        r.ridx = 7'($urandom);
        return r;
    endfunction

    // Driver: one pending transaction at a time, random gap before each.
    int gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_answers.push_back(table_apply({t_req'(i_req_type), i_key_low,
                                                        i_key_high, i_read_index}));
                start <= 1'b0;
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            end else if (!start && pending_reqs.size() > 0) begin
                if (gap > 0) begin
                    gap--;
                end else begin
                    t_request r;
                    r = pending_reqs.pop_front();
                    start <= 1'b1;
                    i_req_type <= r.req;
                    i_key_low <= r.klo;
                    i_key_high <= r.khi;
                    i_read_index <= r.ridx;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid) begin
            if (expected_answers.size() == 0) begin
                $error("unexpected transaction: status %0d", o_status);
                errors++;
            end else begin
                t_answer e;
                e = expected_answers.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, o_status);
                    errors++;
                end
                if (o_slot_index !== e.sidx) begin
                    $error("slot_index: expected %0d actual %0d", e.sidx, o_slot_index);
                    errors++;
                end
                if (o_occupied_count !== e.count) begin
                    $error("occupied_count: expected %0d actual %0d", e.count,
                           o_occupied_count);
                    errors++;
                end
                if (o_slot_occupied !== e.occ) begin
                    $error("slot_occupied: expected %0d actual %0d", e.occ, o_slot_occupied);
                    errors++;
                end
                if (o_slot_key_low !== e.klo) begin
                    $error("slot_key_low: expected %h actual %h", e.klo, o_slot_key_low);
                    errors++;
                end
                if (o_slot_key_high !== e.khi) begin
                    $error("slot_key_high: expected %h actual %h", e.khi, o_slot_key_high);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("open_addressing_string_hash_table_core regression: fail");
            $finish;
        end
    end

    initial begin
        t_request r;
        logic [63:0] lo;
        logic [55:0] hi;
        int n;
        foreach (tbl_mark[i]) tbl_mark[i] = MARK_FREE;
        tbl_used = 0;
        for (int k = 0; k < 16; k++) begin
            n = $urandom_range(1, 15);
            lo = {$urandom, $urandom};
            hi = 56'({$urandom, $urandom});
            for (int i = 0; i < 15; i++) begin
                if (i < 8) begin
                    if (i >= n) lo[8*i +: 8] = 8'd0;
                    else if (lo[8*i +: 8] == 8'd0) lo[8*i +: 8] = 8'd1;
                end else begin
                    if (i >= n) hi[8*(i-8) +: 8] = 8'd0;
                    else if (hi[8*(i-8) +: 8] == 8'd0) hi[8*(i-8) +: 8] = 8'd1;
                end
            end
            key_pool_lo[k] = lo;
            key_pool_hi[k] = hi;
        end
        // directed
        pending_reqs.push_back(key_request(REQ_ADD, 64'd0, 56'd0));
        pending_reqs.push_back(key_request(REQ_DEL, 64'd0, 56'hFF_FFFF));
        pending_reqs.push_back(key_request(REQ_ADD, '1, '1));
        pending_reqs.push_back(key_request(REQ_ADD, '1, '1));
        pending_reqs.push_back(key_request(REQ_ADD, 64'h41, 56'hFF));
        pending_reqs.push_back(key_request(REQ_ADD, 64'hFF00_0042, 56'h0));
        pending_reqs.push_back(key_request(REQ_DEL, 64'h41, 56'h0));
        pending_reqs.push_back(key_request(REQ_DEL, 64'h41, 56'h0));
        pending_reqs.push_back(key_request(REQ_ADD, 64'h41, 56'h0));
        for (int k = 0; k < 8; k++) begin
            r = key_request(REQ_READ, '0, '0);
            r.ridx = (k < 4) ? 7'(k * 33) : 7'(97 + k);
            pending_reqs.push_back(r);
        end
        r.ridx = 7'h7F;
        pending_reqs.push_back(r);
        // many keys with a common home slot to exhaust the probe sequence
        for (int k = 1; k <= 23; k++)
            pending_reqs.push_back(key_request(REQ_ADD, {48'd0, 8'(k), 8'(202 - 2*k)} , 56'd0));
        pending_reqs.push_back(key_request(REQ_CLEAR, '0, '0));
        // random
        for (int k = 0; k < 900; k++) begin
            n = $urandom_range(0, 99);
            if (n < 2) begin
                r = key_request(REQ_CLEAR, {$urandom, $urandom}, 56'({$urandom, $urandom}));
            end else if (n < 20) begin
                r = key_request(REQ_READ, '0, '0);
                r.ridx = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100));
            end else if (n < 28) begin
                r = key_request(t_req'($urandom_range(0, 1)), {$urandom, $urandom},
                                56'({$urandom, $urandom}));
            end else begin
                n = $urandom_range(0, 15);
                r = key_request(($urandom_range(0, 2) == 0) ? REQ_DEL : REQ_ADD,
                                key_pool_lo[n], key_pool_hi[n]);
                if ($urandom_range(0, 3) == 0) r.khi = r.khi | 56'(8'hFF) << 48;
            end
            pending_reqs.push_back(r);
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !start);
        wait (expected_answers.size() == 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && expected_answers.size() == 0)
            $display("open_addressing_string_hash_table_core regression: pass");
        else
            $display("open_addressing_string_hash_table_core regression: fail");
        $finish;
    end
endmodule
